[hw/rtl/leb_pkg.sv]
// Package for the line edit buffer: sizes, key and response item types,
// opcode and status codes, the per-cell command and the sequencer states.
// Used by every module of the block; depends on nothing.
package leb_pkg;

	localparam int LINE_CHARS = 128;
	localparam int CNT_W      = $clog2(LINE_CHARS + 1);
	localparam int IDX_W      = $clog2(LINE_CHARS);
	localparam int RIDX_W     = 7;
	localparam int CMP_W      = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
	localparam int GRP_SIZE   = 16;
	localparam int NUM_GRP    = (LINE_CHARS + GRP_SIZE - 1) / GRP_SIZE;

	typedef enum logic [3:0] {
		OP_CHAR   = 4'd0,
		OP_RIGHT  = 4'd1,
		OP_LEFT   = 4'd2,
		OP_BACK   = 4'd3,
		OP_HOME   = 4'd4,
		OP_END    = 4'd5,
		OP_DELETE = 4'd6,
		OP_TOGGLE = 4'd7,
		OP_READ   = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_IGNORED = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic [3:0]        opcode;
		logic [7:0]        char_code;
		logic [RIDX_W-1:0] read_index;
	} key_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] cursor_pos;
		logic [7:0] line_length;
		logic       overwrite_on;
		logic [7:0] read_char;
	} rsp_item_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] pos;
		logic [7:0]       ch;
	} cell_cmd_t;

	typedef struct packed {
		rsp_item_t rsp;
		logic      rd_ok;
	} ctrl_res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_GATHER
	} state_t;

endpackage

[hw/rtl/leb_cell.sv]
// One character cell of the line store: holds a byte and takes its own,
// its left or right neighbor's value or the new character, per the command.
// Depends on leb_pkg.
module leb_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  leb_pkg::cell_cmd_t        cmd,
	input  logic [leb_pkg::IDX_W-1:0] idx,
	input  logic [7:0]                from_left,
	input  logic [7:0]                from_right,
	input  logic [leb_pkg::CMP_W-1:0] rd_idx,
	output logic [7:0]                data,
	output logic [7:0]                rd_data
);

	logic [7:0] data_q;
	logic [7:0] data_d;

	always_comb begin
		data_d = data_q;
		case (cmd.op)
			leb_pkg::CELL_WRITE: begin
				if (idx == cmd.pos) data_d = cmd.ch;
			end
			leb_pkg::CELL_INSERT: begin
				if (idx > cmd.pos) data_d = from_left;
				else if (idx == cmd.pos) data_d = cmd.ch;
			end
			leb_pkg::CELL_REMOVE: begin
				if (idx >= cmd.pos) data_d = from_right;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			data_q <= data_d;
		end
	end

	assign data    = data_q;
	assign rd_data = (leb_pkg::CMP_W'(idx) == rd_idx) ? data_q : 8'd0;

endmodule

[hw/rtl/leb_ctrl.sv]
// Edit control: holds cursor, length and mode, decodes one key item into
// a command for the row of cells and the response fields.
// Depends on leb_pkg.
module leb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               exec,
	input  leb_pkg::key_item_t item,
	output leb_pkg::cell_cmd_t cmd,
	output leb_pkg::ctrl_res_t res
);

	logic [leb_pkg::CNT_W-1:0] cursor_q;
	logic [leb_pkg::CNT_W-1:0] cursor_d;
	logic [leb_pkg::CNT_W-1:0] length_q;
	logic [leb_pkg::CNT_W-1:0] length_d;
	logic                      mode_q;
	logic                      mode_d;
	logic                      full;
	logic [1:0]                status;
	logic                      rd_ok;
	leb_pkg::cell_cmd_t        cmd_d;

	assign full = (length_q == leb_pkg::CNT_W'(leb_pkg::LINE_CHARS));

	always_comb begin
		cursor_d  = cursor_q;
		length_d  = length_q;
		mode_d    = mode_q;
		status    = leb_pkg::STAT_DONE;
		rd_ok     = 1'b0;
		cmd_d.op  = leb_pkg::CELL_HOLD;
		cmd_d.pos = leb_pkg::IDX_W'(cursor_q);
		cmd_d.ch  = item.char_code;
		case (item.opcode)
			leb_pkg::OP_CHAR: begin
				if (cursor_q >= length_q) begin
					if (!full) begin
						cmd_d.op  = leb_pkg::CELL_WRITE;
						cmd_d.pos = leb_pkg::IDX_W'(length_q);
						length_d  = length_q + leb_pkg::CNT_W'(1);
						cursor_d  = length_q + leb_pkg::CNT_W'(1);
					end else begin
						status = leb_pkg::STAT_FULL;
					end
				end else if (mode_q) begin
					cmd_d.op = leb_pkg::CELL_WRITE;
					cursor_d = cursor_q + leb_pkg::CNT_W'(1);
				end else if (full) begin
					status = leb_pkg::STAT_FULL;
				end else begin
					cmd_d.op = leb_pkg::CELL_INSERT;
					length_d = length_q + leb_pkg::CNT_W'(1);
					cursor_d = cursor_q + leb_pkg::CNT_W'(1);
				end
			end
			leb_pkg::OP_RIGHT: begin
				if (cursor_q < length_q) cursor_d = cursor_q + leb_pkg::CNT_W'(1);
				else status = leb_pkg::STAT_IGNORED;
			end
			leb_pkg::OP_LEFT: begin
				if (cursor_q != '0) cursor_d = cursor_q - leb_pkg::CNT_W'(1);
				else status = leb_pkg::STAT_IGNORED;
			end
			leb_pkg::OP_BACK: begin
				if (cursor_q != '0) begin
					cmd_d.op  = leb_pkg::CELL_REMOVE;
					cmd_d.pos = leb_pkg::IDX_W'(cursor_q - leb_pkg::CNT_W'(1));
					cursor_d  = cursor_q - leb_pkg::CNT_W'(1);
					length_d  = length_q - leb_pkg::CNT_W'(1);
				end else begin
					status = leb_pkg::STAT_IGNORED;
				end
			end
			leb_pkg::OP_HOME: cursor_d = '0;
			leb_pkg::OP_END:  cursor_d = length_q;
			leb_pkg::OP_DELETE: begin
				if (cursor_q < length_q) begin
					cmd_d.op = leb_pkg::CELL_REMOVE;
					length_d = length_q - leb_pkg::CNT_W'(1);
				end else begin
					status = leb_pkg::STAT_IGNORED;
				end
			end
			leb_pkg::OP_TOGGLE: mode_d = ~mode_q;
			leb_pkg::OP_READ: begin
				rd_ok = (leb_pkg::CMP_W'(item.read_index) < leb_pkg::CMP_W'(length_q));
			end
			default: status = leb_pkg::STAT_IGNORED;
		endcase
	end

	always_comb begin
		cmd = cmd_d;
		if (!exec) cmd.op = leb_pkg::CELL_HOLD;
	end

	always_comb begin
		res.rsp.status       = status;
		res.rsp.cursor_pos   = 8'(cursor_d);
		res.rsp.line_length  = 8'(length_d);
		res.rsp.overwrite_on = mode_d;
		res.rsp.read_char    = 8'd0;
		res.rd_ok            = rd_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			length_q <= '0;
			mode_q   <= 1'b0;
		end else if (exec) begin
			cursor_q <= cursor_d;
			length_q <= length_d;
			mode_q   <= mode_d;
		end
	end

endmodule

[hw/rtl/line_edit_buffer.sv]
// Line edit buffer top level: a row of character cells, the edit control,
// a two-level registered read select and the response register.
// Depends on leb_pkg, leb_cell and leb_ctrl.
// The key item is registered on accept; in the execute state the control result and
// the read groups are registered, and in the gather state the response; no new item is
// taken before then. A stalled response holds off the next gather until it is taken.
// Reset clears all cells, cursor, length and mode at once.
module line_edit_buffer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_valid,
	output logic               key_stall,
	input  leb_pkg::key_item_t key_item,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output leb_pkg::rsp_item_t rsp_item
);

	localparam int ROW_W = leb_pkg::NUM_GRP * leb_pkg::GRP_SIZE;

	leb_pkg::state_t    state_q;
	leb_pkg::state_t    state_d;
	logic               exec;
	logic               gather;
	logic               slot_free;
	leb_pkg::key_item_t item_s1;
	leb_pkg::cell_cmd_t cmd;
	leb_pkg::ctrl_res_t res;
	leb_pkg::ctrl_res_t res_s2;
	logic [7:0]         cell_data [leb_pkg::LINE_CHARS];
	logic [7:0]         rd_vec    [ROW_W];
	logic [7:0]         grp_d     [leb_pkg::NUM_GRP];
	logic [7:0]         grp_s2    [leb_pkg::NUM_GRP];
	logic [7:0]         rd_all;
	logic               rsp_valid_q;
	leb_pkg::rsp_item_t rsp_item_q;
	leb_pkg::rsp_item_t rsp_next;
	logic [leb_pkg::CMP_W-1:0] rd_idx;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			leb_pkg::S_IDLE:   if (key_valid) state_d = leb_pkg::S_EXEC;
			leb_pkg::S_EXEC:   state_d = leb_pkg::S_GATHER;
			leb_pkg::S_GATHER: if (slot_free) state_d = leb_pkg::S_IDLE;
			default:           state_d = leb_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		key_stall = (state_q != leb_pkg::S_IDLE);
		exec      = (state_q == leb_pkg::S_EXEC);
		gather    = (state_q == leb_pkg::S_GATHER) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= leb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (key_valid && !key_stall) item_s1 <= key_item;
	end

	leb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.exec   (exec),
		.item   (item_s1),
		.cmd    (cmd),
		.res    (res)
	);

	assign rd_idx = leb_pkg::CMP_W'(item_s1.read_index);

	for (genvar i = 0; i < ROW_W; i++) begin : g_row
		if (i < leb_pkg::LINE_CHARS) begin : g_cell
			logic [7:0] left;
			logic [7:0] right;
			if (i == 0) begin : g_first
				assign left = 8'd0;
			end else begin : g_inner_l
				assign left = cell_data[i-1];
			end
			if (i == leb_pkg::LINE_CHARS - 1) begin : g_last
				assign right = 8'd0;
			end else begin : g_inner_r
				assign right = cell_data[i+1];
			end
			leb_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.idx        (leb_pkg::IDX_W'(i)),
				.from_left  (left),
				.from_right (right),
				.rd_idx     (rd_idx),
				.data       (cell_data[i]),
				.rd_data    (rd_vec[i])
			);
		end else begin : g_pad
			assign rd_vec[i] = 8'd0;
		end
	end

	always_comb begin
		for (int g = 0; g < leb_pkg::NUM_GRP; g++) begin
			grp_d[g] = 8'd0;
			for (int k = 0; k < leb_pkg::GRP_SIZE; k++) begin
				grp_d[g] = grp_d[g] | rd_vec[g * leb_pkg::GRP_SIZE + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_s2 <= res;
			for (int g = 0; g < leb_pkg::NUM_GRP; g++) begin
				grp_s2[g] <= grp_d[g];
			end
		end
	end

	always_comb begin
		rd_all = 8'd0;
		for (int g = 0; g < leb_pkg::NUM_GRP; g++) begin
			rd_all = rd_all | grp_s2[g];
		end
		rsp_next           = res_s2.rsp;
		rsp_next.read_char = res_s2.rd_ok ? rd_all : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (gather) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gather) rsp_item_q <= rsp_next;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

endmodule

[hw/rtl/leb_checker.sv]
// Port-level checks for the line edit buffer, attached by the bind below.
// Depends on leb_pkg and the line_edit_buffer top level.
module leb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               key_valid,
	input logic               key_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input leb_pkg::rsp_item_t rsp_item
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_stall |=> key_stall)
		else $error("Key item accepted while the previous one was in work.");

	a_rsp_follows_key: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_stall && !rsp_valid |-> ##3 rsp_valid)
		else $error("Response did not appear three edges after the key item.");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.status == leb_pkg::STAT_FULL
		|-> rsp_item.line_length == 8'(leb_pkg::LINE_CHARS))
		else $error("Line full status with a line that is not full.");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("Stalled response item changed.");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);
